[hdl/assert_macros.svh]
// Assertion helpers, clocked on clk and quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/gcs_pkg.sv]
package gcs_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int MAX_GLYPHS = 1024;

	localparam int CH_W = 8;
	localparam int COLOR_W = 3 * CH_W;
	localparam int IDX_W = 10;
	localparam int CNT_W = 11;
	localparam int OP_W = 2;
	localparam int MODE_W = 2;
	localparam int CFG_IDX_W = 2;

	localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
	localparam int DEN_W = ($clog2(MAX_GLYPHS) < CNT_W) ? $clog2(MAX_GLYPHS) : CNT_W;
	localparam int PROD_W = CH_W + IDX_W;

	localparam int DIV_RADIX = 4;
	localparam int DIV_STEPS = (PROD_W + DIV_RADIX - 1) / DIV_RADIX;
	localparam int DIV_W = DIV_STEPS * DIV_RADIX;
	localparam int STEP_W = $clog2(DIV_STEPS + 1);

	localparam int IN_TDATA_W = ((IDX_W + CNT_W + COLOR_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((COLOR_W + 7) / 8) * 8;

	localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd2;

	localparam logic [MODE_W-1:0] MODE_SOLID = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GRADIENT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LETTER = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOLID_COLOR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRADIENT_START = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GRADIENT_END = 2'd3;

	localparam logic [1:0] CH_RED = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE = 2'd2;

	typedef struct packed {
		logic start;
		logic [PROD_W-1:0] dividend;
		logic [DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [PROD_W-1:0] quotient;
	} div_rsp_t;

endpackage

[hdl/gcs_ram.sv]
module gcs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/gcs_div.sv]
module gcs_div (
	input  logic clk,
	input  logic arst_n,
	input  gcs_pkg::div_req_t req,
	output gcs_pkg::div_rsp_t rsp
);

	logic [gcs_pkg::DIV_W-1:0] work_q;
	logic [gcs_pkg::DEN_W-1:0] rem_q;
	logic [gcs_pkg::DEN_W-1:0] den_q;
	logic [gcs_pkg::STEP_W-1:0] step_q;
	logic done_q;

	logic [gcs_pkg::DIV_W-1:0] work_n;
	logic [gcs_pkg::DEN_W-1:0] rem_n;
	logic [gcs_pkg::DEN_W:0] trial;

	// Restoring division, several quotient bits per cycle.
	always_comb begin
		rem_n = rem_q;
		work_n = work_q;
		trial = '0;
		for (int k = 0; k < gcs_pkg::DIV_RADIX; k++) begin
			trial = {rem_n, work_n[gcs_pkg::DIV_W-1]};
			work_n = {work_n[gcs_pkg::DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_n = gcs_pkg::DEN_W'(trial - {1'b0, den_q});
				work_n[0] = 1'b1;
			end else begin
				rem_n = trial[gcs_pkg::DEN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (step_q == gcs_pkg::STEP_W'(1));
			if (req.start) begin
				step_q <= gcs_pkg::STEP_W'(gcs_pkg::DIV_STEPS);
			end else if (step_q != '0) begin
				step_q <= step_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= gcs_pkg::DIV_W'(req.dividend);
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (step_q != '0) begin
			work_q <= work_n;
			rem_q <= rem_n;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = work_q[gcs_pkg::PROD_W-1:0];

endmodule

[hdl/glyph_color_selector.sv]
// Glyph color selector: returns the RGB color of one glyph of a scrolling text.
// Items arrive on the s_axis channel; tuser carries the operation (query, clear
// table, append table entry) and tdata the glyph index, glyph count and entry
// color. Only a query produces a transfer on the m_axis channel, carrying red,
// green and blue. Registers are written through cfg_we, cfg_index and cfg_data
// while the block is idle; the user must keep to this, as the block does not
// enforce it. A clear or append leaves the block idle, so s_axis_tready stays
// high. A solid color query goes from acceptance to S_DONE, which loads the
// output register; a table query first reads the table in S_TBL. A gradient
// query runs the shared multiply and divide unit once per channel, S_MUL then
// S_DIV; that unit sets the throughput of gradient queries.
// The result sits in an output register, so the next item is accepted while it
// waits; if the receiver stalls, a further query holds at its last step until
// the register frees. Reset clears the registers, the table fill and the output
// valid, and the block starts idle; table contents are undefined until appended.
`include "assert_macros.svh"

module glyph_color_selector (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// glyph_index, glyph_count, entry_red, entry_green, entry_blue, zero fill
	input  logic [gcs_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	// op
	input  logic [gcs_pkg::OP_W-1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// out_red, out_green, out_blue
	output logic [gcs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic cfg_we,
	input  logic [gcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gcs_pkg::COLOR_W-1:0] cfg_data
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MUL  = 5'b00010,
		S_DIV  = 5'b00100,
		S_TBL  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	localparam int CNT_LSB = gcs_pkg::IDX_W;
	localparam int RED_LSB = CNT_LSB + gcs_pkg::CNT_W;
	localparam int GRN_LSB = RED_LSB + gcs_pkg::CH_W;
	localparam int BLU_LSB = GRN_LSB + gcs_pkg::CH_W;

	state_t state_q;
	logic [gcs_pkg::MODE_W-1:0] color_mode_q;
	logic [gcs_pkg::COLOR_W-1:0] solid_color_q;
	logic [gcs_pkg::COLOR_W-1:0] gradient_start_q;
	logic [gcs_pkg::COLOR_W-1:0] gradient_end_q;
	logic [gcs_pkg::FILL_W-1:0] fill_q;
	logic [gcs_pkg::IDX_W-1:0] idx_q;
	logic [gcs_pkg::DEN_W-1:0] den_q;
	logic [1:0] ch_q;
	logic [gcs_pkg::COLOR_W-1:0] color_q;
	logic use_tbl_q;
	logic out_valid_q;
	logic [gcs_pkg::OUT_TDATA_W-1:0] out_data_q;

	logic s_accept;
	logic [gcs_pkg::IDX_W-1:0] in_idx;
	logic [gcs_pkg::CNT_W-1:0] in_cnt;
	logic [gcs_pkg::CNT_W-1:0] cnt_sat;
	logic [gcs_pkg::COLOR_W-1:0] in_color;
	logic tbl_hit;
	logic tbl_we;
	logic [gcs_pkg::COLOR_W-1:0] tbl_rdata;
	logic [gcs_pkg::CH_W-1:0] s_byte;
	logic [gcs_pkg::CH_W-1:0] e_byte;
	logic [gcs_pkg::CH_W:0] diff;
	logic [gcs_pkg::CH_W-1:0] diff_mag;
	logic [gcs_pkg::CH_W-1:0] q_low;
	logic [gcs_pkg::CH_W-1:0] blend_byte;
	logic [gcs_pkg::COLOR_W-1:0] final_color;
	gcs_pkg::div_req_t div_req;
	gcs_pkg::div_rsp_t div_rsp;

	assign s_axis_tready = (state_q == S_IDLE);
	assign s_accept = s_axis_tvalid && s_axis_tready;
	assign in_idx = s_axis_tdata[CNT_LSB-1:0];
	assign in_cnt = s_axis_tdata[RED_LSB-1:CNT_LSB];
	assign in_color = {s_axis_tdata[GRN_LSB-1:RED_LSB], s_axis_tdata[BLU_LSB-1:GRN_LSB],
		s_axis_tdata[BLU_LSB+gcs_pkg::CH_W-1:BLU_LSB]};
	assign cnt_sat = (32'(in_cnt) > gcs_pkg::MAX_GLYPHS) ?
		gcs_pkg::CNT_W'(gcs_pkg::MAX_GLYPHS) : in_cnt;
	assign tbl_hit = (32'(in_idx) < 32'(fill_q)) && (32'(in_idx) < gcs_pkg::TABLE_DEPTH);
	assign tbl_we = s_accept && (s_axis_tuser == gcs_pkg::OP_APPEND)
		&& (32'(fill_q) < gcs_pkg::TABLE_DEPTH);

	gcs_ram #(
		.WIDTH(gcs_pkg::COLOR_W),
		.DEPTH(gcs_pkg::TABLE_DEPTH)
	) u_table (
		.clk(clk),
		.we(tbl_we),
		.waddr(fill_q[gcs_pkg::ADDR_W-1:0]),
		.wdata(in_color),
		.re(state_q == S_TBL),
		.raddr(idx_q[gcs_pkg::ADDR_W-1:0]),
		.rdata(tbl_rdata)
	);

	always_comb begin
		case (ch_q)
			gcs_pkg::CH_RED: begin
				s_byte = gradient_start_q[23:16];
				e_byte = gradient_end_q[23:16];
			end
			gcs_pkg::CH_GREEN: begin
				s_byte = gradient_start_q[15:8];
				e_byte = gradient_end_q[15:8];
			end
			default: begin
				s_byte = gradient_start_q[7:0];
				e_byte = gradient_end_q[7:0];
			end
		endcase
	end

	assign diff = {1'b0, e_byte} - {1'b0, s_byte};
	assign diff_mag = diff[gcs_pkg::CH_W] ? gcs_pkg::CH_W'(-diff) : diff[gcs_pkg::CH_W-1:0];
	assign q_low = div_rsp.quotient[gcs_pkg::CH_W-1:0];
	assign blend_byte = s_byte + (diff[gcs_pkg::CH_W] ? gcs_pkg::CH_W'(-q_low) : q_low);

	assign div_req.start = (state_q == S_MUL);
	assign div_req.dividend = gcs_pkg::PROD_W'(diff_mag) * gcs_pkg::PROD_W'(idx_q);
	assign div_req.divisor = den_q;

	gcs_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	assign final_color = use_tbl_q ? tbl_rdata : color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q <= gcs_pkg::MODE_SOLID;
			solid_color_q <= '0;
			gradient_start_q <= '0;
			gradient_end_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gcs_pkg::REG_COLOR_MODE: color_mode_q <= cfg_data[gcs_pkg::MODE_W-1:0];
				gcs_pkg::REG_SOLID_COLOR: solid_color_q <= cfg_data;
				gcs_pkg::REG_GRADIENT_START: gradient_start_q <= cfg_data;
				gcs_pkg::REG_GRADIENT_END: gradient_end_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			ch_q <= gcs_pkg::CH_RED;
			use_tbl_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						use_tbl_q <= 1'b0;
						ch_q <= gcs_pkg::CH_RED;
						unique case (s_axis_tuser)
							gcs_pkg::OP_CLEAR: fill_q <= '0;
							gcs_pkg::OP_APPEND: begin
								if (tbl_we) begin
									fill_q <= fill_q + 1'b1;
								end
							end
							gcs_pkg::OP_QUERY: begin
								if (color_mode_q == gcs_pkg::MODE_GRADIENT) begin
									if (cnt_sat > gcs_pkg::CNT_W'(1)) begin
										state_q <= S_MUL;
									end else begin
										state_q <= S_DONE;
									end
								end else if (color_mode_q == gcs_pkg::MODE_LETTER && tbl_hit) begin
									use_tbl_q <= 1'b1;
									state_q <= S_TBL;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: ;
						endcase
					end
				end
				S_MUL: state_q <= S_DIV;
				S_DIV: begin
					if (div_rsp.done) begin
						if (ch_q == gcs_pkg::CH_BLUE) begin
							state_q <= S_DONE;
						end else begin
							ch_q <= ch_q + 1'b1;
							state_q <= S_MUL;
						end
					end
				end
				S_TBL: state_q <= S_DONE;
				S_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			idx_q <= in_idx;
			den_q <= gcs_pkg::DEN_W'(cnt_sat - 1'b1);
			if (color_mode_q == gcs_pkg::MODE_GRADIENT) begin
				color_q <= gradient_start_q;
			end else begin
				color_q <= solid_color_q;
			end
		end else if (state_q == S_DIV && div_rsp.done) begin
			case (ch_q)
				gcs_pkg::CH_RED: color_q[23:16] <= blend_byte;
				gcs_pkg::CH_GREEN: color_q[15:8] <= blend_byte;
				default: color_q[7:0] <= blend_byte;
			endcase
		end
		if (state_q == S_DONE && (!out_valid_q || m_axis_tready)) begin
			out_data_q <= gcs_pkg::OUT_TDATA_W'({final_color[7:0], final_color[15:8],
				final_color[23:16]});
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	`ASSERT_ALWAYS(a_fill_bound, 32'(fill_q) <= gcs_pkg::TABLE_DEPTH, "table fill past depth")
	`ASSERT_IMPLIES(a_div_done_state, div_rsp.done, state_q == S_DIV, "divider done outside S_DIV")
	`ASSERT_NEXT(a_clear_empties, s_accept && s_axis_tuser == gcs_pkg::OP_CLEAR, fill_q == '0, "clear did not empty table")
	`ASSERT_IMPLIES(a_result_source, $rose(m_axis_tvalid), $past(state_q == S_DONE), "result without finished query")

endmodule
